[hw/rtl/assert_macros.svh]
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assert failed");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error("never failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

[hw/rtl/gbi_pkg.sv]
package gbi_pkg;
    localparam int unsigned ATAN_N = 24;
    localparam logic signed [31:0] CORDIC_X0 = 32'sd652032874;

    typedef enum logic [1:0] {
        REG_REST_THRESHOLD = 2'd0,
        REG_PHASE_GAIN     = 2'd1,
        REG_ARM_LENGTH     = 2'd2
    } t_reg_idx;

    function automatic logic [31:0] atan_turns(input logic [4:0] idx);
        case (idx)
            5'd0:  atan_turns = 32'h20000000;
            5'd1:  atan_turns = 32'h12E4051E;
            5'd2:  atan_turns = 32'h09FB385B;
            5'd3:  atan_turns = 32'h051111D4;
            5'd4:  atan_turns = 32'h028B0D43;
            5'd5:  atan_turns = 32'h0145D7E1;
            5'd6:  atan_turns = 32'h00A2F61E;
            5'd7:  atan_turns = 32'h00517C55;
            5'd8:  atan_turns = 32'h0028BE53;
            5'd9:  atan_turns = 32'h00145F2F;
            5'd10: atan_turns = 32'h000A2F98;
            5'd11: atan_turns = 32'h000517CC;
            5'd12: atan_turns = 32'h00028BE6;
            5'd13: atan_turns = 32'h000145F3;
            5'd14: atan_turns = 32'h0000A2FA;
            5'd15: atan_turns = 32'h0000517D;
            5'd16: atan_turns = 32'h000028BE;
            5'd17: atan_turns = 32'h0000145F;
            5'd18: atan_turns = 32'h00000A30;
            5'd19: atan_turns = 32'h00000518;
            5'd20: atan_turns = 32'h0000028C;
            5'd21: atan_turns = 32'h00000146;
            5'd22: atan_turns = 32'h000000A3;
            5'd23: atan_turns = 32'h00000051;
            default: atan_turns = 32'h0;
        endcase
    endfunction
endpackage

[hw/rtl/gyro_bump_integrator.sv]
// Gyro bump integrator. Each gyro beat lands in a ring window; once the window is full
// the integrator gains (depth * mid sample - window sum), saturating. The phase
// (integrator times phase_gain, mod one turn) goes through an iterative CORDIC,
// the sine is scaled by arm_length, saturated and reported with running max and min.
// With the window full, the sum pass, the mid-sample read, the accumulate, the phase
// multiply and the CORDIC follow in that order. The next beat is taken only after
// the result beat has been accepted, so a new beat is never taken while the last
// one is still in flight. The window sum reads the window RAM one entry a cycle.
// While the window is not full, or when a restart empties it, the sum and CORDIC
// are skipped and a result with bump_valid low and value zero is given.
// A stalled result beat holds off the input. After reset a clearing pass zeroes
// the window before the first beat is taken. Only the low 32 bits of the phase
// product matter, so one 32x32 multiply of the integrator's low word gives the phase.
`include "assert_macros.svh"
module gyro_bump_integrator #(
    parameter int WINDOW_DEPTH = 64,
    parameter int CORDIC_STEPS = 16,
    parameter int ACC_WIDTH    = 48
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_gyro_sample,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_bump_valid,
    output logic signed [15:0] o_bump_value,
    output logic signed [15:0] o_bump_max,
    output logic signed [15:0] o_bump_min
);
    import gbi_pkg::*;

    localparam int AW   = $clog2(WINDOW_DEPTH);
    localparam int SW   = 16 + AW + 1;
    localparam int HALF = WINDOW_DEPTH / 2;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_WRITE, S_SUM, S_MID, S_ACC, S_MUL0, S_MUL1,
        S_CORD, S_SCALE, S_OUT
    } t_state;

    t_state r_state;
    logic [14:0] r_thr;
    logic [31:0] r_gain;
    logic [15:0] r_len;
    logic [AW-1:0] r_wp, r_cnt, r_addr;
    logic r_full, r_last;
    logic signed [ACC_WIDTH-1:0] r_acc;
    logic signed [SW-1:0] r_sum;
    logic signed [15:0] r_max, r_min, r_bump, r_sample;
    logic r_bvalid, r_ovalid;
    logic [31:0] r_phase;
    logic signed [32:0] r_prod;
    logic r_cstart;

    logic ram_we;
    logic [AW-1:0] ram_waddr;
    logic [15:0] ram_wdata, ram_rdata;
    logic cdone;
    logic signed [15:0] csine;

    logic [AW-1:0] wp_inc, mid_addr;
    logic restart, wrapped;
    logic signed [ACC_WIDTH+1:0] acc_sum, inc;
    logic signed [ACC_WIDTH+1:0] acc_hi, acc_lo;
    logic [31:0] pp0;
    logic signed [32:0] q;
    logic signed [15:0] q_sat;

    gbi_ram #(.WIDTH(16), .DEPTH(WINDOW_DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(r_addr),
        .o_rdata(ram_rdata)
    );

    gbi_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_cstart),
        .i_phase(r_phase),
        .o_done (cdone),
        .o_sine (csine)
    );

    // datapath helpers
    always_comb begin
        ram_we    = (r_state == S_CLEAR) || (r_state == S_WRITE);
        ram_waddr = (r_state == S_CLEAR) ? r_cnt : r_wp;
        ram_wdata = (r_state == S_CLEAR) ? 16'h0 : r_sample;
        wp_inc    = (r_wp == AW'(WINDOW_DEPTH - 1)) ? '0 : r_wp + AW'(1);
        wrapped   = (wp_inc == '0);
        mid_addr  = (r_wp >= AW'(WINDOW_DEPTH - HALF)) ? r_wp - AW'(WINDOW_DEPTH - HALF)
                                                        : r_wp + AW'(HALF);
        restart   = (($signed({1'b0, r_thr}) < $signed(r_sample))
                     || ($signed(r_sample) < -$signed({1'b0, r_thr})))
                    && (r_acc == '0);
        inc     = (ACC_WIDTH+2)'($signed(ram_rdata)) * (ACC_WIDTH+2)'(WINDOW_DEPTH)
                  - (ACC_WIDTH+2)'(r_sum);
        acc_sum = (ACC_WIDTH+2)'(r_acc) + inc;
        acc_hi  = (ACC_WIDTH+2)'({1'b0, {(ACC_WIDTH-1){1'b1}}});
        acc_lo  = -acc_hi - (ACC_WIDTH+2)'(1);
        pp0     = r_acc[31:0] * r_gain;
        q       = (r_prod + (r_prod[32] ? 33'sd32767 : 33'sd0)) >>> 15;
        if (q > 33'sd32767) begin
            q_sat = 16'sh7FFF;
        end else if (q < -33'sd32768) begin
            q_sat = -16'sh8000;
        end else begin
            q_sat = q[15:0];
        end
    end

    // sequencer and registered results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_thr    <= 15'd200;
            r_gain   <= '0;
            r_len    <= '0;
            r_wp     <= '0;
            r_cnt    <= '0;
            r_full   <= 1'b0;
            r_acc    <= '0;
            r_max    <= -16'sh8000;
            r_min    <= 16'sh7FFF;
            r_ovalid <= 1'b0;
            r_cstart <= 1'b0;
            r_addr   <= '0;
        end else begin
            r_cstart <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_REST_THRESHOLD: r_thr  <= i_cfg_data[14:0];
                    REG_PHASE_GAIN:     r_gain <= i_cfg_data;
                    REG_ARM_LENGTH:     r_len  <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_cnt <= r_cnt + AW'(1);
                    if (r_cnt == AW'(WINDOW_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_valid && !r_ovalid) begin
                        r_sample <= i_gyro_sample;
                        r_state  <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    r_wp <= wp_inc;
                    if (wrapped) begin
                        r_full <= 1'b1;
                    end
                    if (restart) begin
                        r_wp   <= '0;
                        r_full <= 1'b0;
                    end
                    if ((r_full || wrapped) && !restart) begin
                        r_sum   <= '0;
                        r_cnt   <= '0;
                        r_addr  <= '0;
                        r_last  <= 1'b0;
                        r_state <= S_SUM;
                    end else begin
                        r_bvalid <= 1'b0;
                        r_bump   <= '0;
                        r_state  <= S_OUT;
                    end
                end
                S_SUM: begin
                    // read data arrives in the cycle after its address
                    if (r_cnt != '0 || r_last) begin
                        r_sum <= r_sum + SW'($signed(ram_rdata));
                    end
                    r_addr <= r_addr + AW'(1);
                    r_cnt  <= r_cnt + AW'(1);
                    if (r_last) begin
                        r_addr  <= mid_addr;
                        r_state <= S_MID;
                    end
                    if (r_cnt == AW'(WINDOW_DEPTH - 1)) begin
                        r_last <= 1'b1;
                    end
                end
                S_MID: begin
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (acc_sum > acc_hi) begin
                        r_acc <= acc_hi[ACC_WIDTH-1:0];
                    end else if (acc_sum < acc_lo) begin
                        r_acc <= acc_lo[ACC_WIDTH-1:0];
                    end else begin
                        r_acc <= acc_sum[ACC_WIDTH-1:0];
                    end
                    r_state <= S_MUL0;
                end
                S_MUL0: begin
                    r_phase <= pp0;
                    r_state <= S_MUL1;
                end
                S_MUL1: begin
                    r_cstart <= 1'b1;
                    r_state  <= S_CORD;
                end
                S_CORD: begin
                    if (cdone) begin
                        r_prod  <= 33'($signed({1'b0, r_len})) * 33'(csine);
                        r_state <= S_SCALE;
                    end
                end
                S_SCALE: begin
                    r_bump   <= q_sat;
                    r_bvalid <= 1'b1;
                    if (q_sat > r_max) r_max <= q_sat;
                    if (q_sat < r_min) r_min <= q_sat;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready      = (r_state == S_IDLE) && !r_ovalid;
    assign o_valid      = r_ovalid;
    assign o_bump_valid = r_bvalid;
    assign o_bump_value = r_bump;
    assign o_bump_max   = r_max;
    assign o_bump_min   = r_min;

    `ASSERT_NEVER(a_no_accept_busy, i_clk, i_rst_n, o_ready && r_state != S_IDLE)
    `ASSERT_IMPL(a_minmax, i_clk, i_rst_n, (o_valid && o_bump_valid) |-> (o_bump_min <= o_bump_max))
    `ASSERT_IMPL(a_out_zero, i_clk, i_rst_n, (o_valid && !o_bump_valid) |-> (o_bump_value == 16'sd0))
endmodule

[hw/rtl/gbi_ram.sv]
module gbi_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[hw/rtl/gbi_cordic.sv]
module gbi_cordic #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [31:0]        i_phase,
    output logic               o_done,
    output logic signed [15:0] o_sine
);
    import gbi_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_ROT, S_FIN} t_state;
    t_state r_state;
    logic signed [33:0] r_x, r_y;
    logic signed [32:0] r_z;
    logic [4:0] r_i;
    logic r_flip, r_done;
    logic signed [15:0] r_sine;
    logic [31:0] ph;
    logic signed [33:0] dx, dy;
    logic signed [32:0] at;
    logic signed [33:0] s;
    logic signed [33:0] sn;

    // phase fold into the right half plane, shift terms and rounding of the sine
    always_comb begin
        ph = i_phase ^ {(i_phase[31] != i_phase[30]), 31'b0};
        dx = r_y >>> r_i;
        dy = r_x >>> r_i;
        at = $signed({1'b0, atan_turns(r_i)});
        s  = (r_y + 34'sd16384) >>> 15;
        sn = r_flip ? -s : s;
    end

    // rotation sequencer, one micro-rotation per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_flip  <= i_phase[31] != i_phase[30];
                        r_x     <= 34'(CORDIC_X0);
                        r_y     <= '0;
                        r_z     <= 33'($signed(ph));
                        r_i     <= '0;
                        r_state <= S_ROT;
                    end
                end
                S_ROT: begin
                    if (!r_z[32]) begin
                        r_x <= r_x - dx;
                        r_y <= r_y + dy;
                        r_z <= r_z - at;
                    end else begin
                        r_x <= r_x + dx;
                        r_y <= r_y - dy;
                        r_z <= r_z + at;
                    end
                    r_i <= r_i + 5'd1;
                    if (r_i == 5'(CORDIC_STEPS - 1)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (sn > 34'sd32767) begin
                        r_sine <= 16'sh7FFF;
                    end else if (sn < -34'sd32768) begin
                        r_sine <= -16'sh8000;
                    end else begin
                        r_sine <= sn[15:0];
                    end
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_sine = r_sine;
endmodule

[dv/gyro_bump_checker.sv]
`timescale 1ns / 1ps
module gyro_bump_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_valid,
    input  logic               i_ready_in,
    input  logic signed [15:0] i_gyro_sample,
    input  logic               i_valid_out,
    input  logic               i_ready,
    input  logic               i_bump_valid,
    input  logic signed [15:0] i_bump_value,
    input  logic signed [15:0] i_bump_max,
    input  logic signed [15:0] i_bump_min,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_bump_count
);
    import gbi_pkg::*;

    localparam int DEPTH = 64;
    localparam int STEPS = 16;
    localparam logic signed [47:0] ACC_HI = {1'b0, {47{1'b1}}};
    localparam logic signed [47:0] ACC_LO = {1'b1, {47{1'b0}}};

    typedef struct packed {
        logic               bvalid;
        logic signed [15:0] value;
        logic signed [15:0] vmax;
        logic signed [15:0] vmin;
    } t_bump;

    // predictor state
    logic [14:0]        rest_thr;
    logic [31:0]        gain;
    logic [15:0]        arm_len;
    logic signed [15:0] win [DEPTH];
    logic [5:0]         wr_ptr;
    logic               full;
    logic signed [47:0] integ;
    logic signed [15:0] hi_seen;
    logic signed [15:0] lo_seen;
    t_bump              bump_queue[$];

    function automatic logic signed [63:0] cordic_sine(input logic [31:0] phase);
        logic               flip;
        logic signed [63:0] x, y, z, dx, dy, s;
        logic [31:0]        ang;
        flip = phase[31] != phase[30];
        ang = flip ? (phase ^ 32'h8000_0000) : phase;
        z = {{32{ang[31]}}, ang};
        x = 64'(CORDIC_X0);
        y = 0;
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx; y = y + dy; z = z - 64'(atan_turns(5'(i)));
            end else begin
                x = x + dx; y = y - dy; z = z + 64'(atan_turns(5'(i)));
            end
        end
        s = (y + 64'sd16384) >>> 15;
        if (flip) s = -s;
        if (s > 32767) s = 32767;
        if (s < -32768) s = -32768;
        return s;
    endfunction

    task automatic predict_bump(input logic signed [15:0] g);
        t_bump              r;
        logic signed [63:0] sum, inc, acc, prod, t;
        logic [63:0]        full_prod;
        t = {49'd0, rest_thr};
        win[wr_ptr] = g;
        wr_ptr = wr_ptr + 6'd1;
        if (wr_ptr == 0) full = 1'b1;
        if ((64'(g) > t || 64'(g) < -t) && integ == 0) begin
            wr_ptr = 0;
            full = 1'b0;
        end
        r = '0;
        if (full) begin
            sum = 0;
            for (int i = 0; i < DEPTH; i++) sum += 64'(win[i]);
            inc = 64'(DEPTH) * 64'(win[6'(wr_ptr + DEPTH / 2)]) - sum;
            acc = 64'(integ) + inc;
            if (acc > 64'(ACC_HI)) acc = 64'(ACC_HI);
            if (acc < 64'(ACC_LO)) acc = 64'(ACC_LO);
            integ = 48'(acc);
            full_prod = 64'(integ) * {32'd0, gain};
            prod = $signed({48'd0, arm_len}) * cordic_sine(full_prod[31:0]);
            prod = prod / 64'sd32768;
            if (prod > 32767) prod = 32767;
            if (prod < -32768) prod = -32768;
            r.value = 16'(prod);
            r.bvalid = 1'b1;
            if (r.value > hi_seen) hi_seen = r.value;
            if (r.value < lo_seen) lo_seen = r.value;
        end
        r.vmax = hi_seen;
        r.vmin = lo_seen;
        bump_queue.push_back(r);
    endtask

    always @(posedge i_clk) begin
        t_bump e;
        int    errs;
        errs = 0;
        if (!i_rst_n) begin
            rest_thr <= 15'd200;
            gain     <= '0;
            arm_len  <= '0;
            for (int i = 0; i < DEPTH; i++) win[i] = '0;
            wr_ptr   = '0;
            full     = 1'b0;
            integ    = '0;
            hi_seen  = -16'sd32768;
            lo_seen  = 16'sd32767;
            o_fail_count <= 0;
            o_bump_count <= 0;
        end else begin
            // register writes
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_REST_THRESHOLD: rest_thr <= i_cfg_data[14:0];
                    REG_PHASE_GAIN:     gain <= i_cfg_data;
                    REG_ARM_LENGTH:     arm_len <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            // result beat
            if (i_valid_out && i_ready) begin
                if (bump_queue.size() == 0) begin
                    $error("result beat with nothing expected");
                    errs++;
                end else begin
                    e = bump_queue.pop_front();
                    if (e.bvalid) o_bump_count <= o_bump_count + 1;
                    if (i_bump_valid !== e.bvalid) begin
                        $error("bump_valid exp %0d got %0d", e.bvalid, i_bump_valid);
                        errs++;
                    end
                    if (i_bump_value !== e.value) begin
                        $error("bump_value exp %0d got %0d", e.value, i_bump_value);
                        errs++;
                    end
                    if (i_bump_max !== e.vmax) begin
                        $error("bump_max exp %0d got %0d", e.vmax, i_bump_max);
                        errs++;
                    end
                    if (i_bump_min !== e.vmin) begin
                        $error("bump_min exp %0d got %0d", e.vmin, i_bump_min);
                        errs++;
                    end
                end
            end
            o_fail_count <= o_fail_count + errs;
            // input beat
            if (i_valid && i_ready_in) predict_bump(i_gyro_sample);
        end
        o_pending <= bump_queue.size();
    end
endmodule

[dv/gyro_bump_integrator_test.sv]
`timescale 1ns / 1ps
module gyro_bump_integrator_test;
    import gbi_pkg::*;

    localparam int LIMIT = 1500000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [1:0]         cfg_index = '0;
    logic [31:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic signed [15:0] gyro = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic               bump_valid;
    logic signed [15:0] bump_value, bump_max, bump_min;
    int                 fail_count, pending, bump_count;
    int                 cycles = 0;
    int                 sent = 0;
    bit                 hold_off = 1'b0;

    always #10 i_clk = ~i_clk;

    gyro_bump_integrator u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_valid(in_valid), .o_ready(in_ready), .i_gyro_sample(gyro),
        .o_valid(out_valid), .i_ready(out_ready),
        .o_bump_valid(bump_valid), .o_bump_value(bump_value),
        .o_bump_max(bump_max), .o_bump_min(bump_min)
    );

    gyro_bump_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_valid(in_valid), .i_ready_in(in_ready), .i_gyro_sample(gyro),
        .i_valid_out(out_valid), .i_ready(out_ready),
        .i_bump_valid(bump_valid), .i_bump_value(bump_value),
        .i_bump_max(bump_max), .i_bump_min(bump_min),
        .o_fail_count(fail_count), .o_pending(pending), .o_bump_count(bump_count)
    );

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver stalls on its own pattern, with one long hold-off
    always @(posedge i_clk) begin
        int r;
        r = $urandom_range(0, 99);
        if (!i_rst_n) out_ready <= 1'b0;
        else if (hold_off) out_ready <= 1'b0;
        else if ((cycles / 3000) % 3 == 0) out_ready <= 1'b1;
        else out_ready <= r < 60;
    end

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] val);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_gyro(input logic signed [15:0] g);
        in_valid <= 1'b1;
        gyro <= g;
        do @(posedge i_clk); while (!in_ready);
        sent++;
    endtask

    // bursts with random gaps
    task automatic send_burst(input logic signed [15:0] g, input bit gap);
        int idle;
        send_gyro(g);
        if (gap && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            idle = $urandom_range(1, 40);
            repeat (idle) @(posedge i_clk);
        end
    endtask

    task automatic settle;
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    // mostly quiet samples with a bump, plus noise
    function automatic logic signed [15:0] rand_gyro(input int mode);
        case (mode)
            0: return 16'($urandom_range(0, 400)) - 16'sd200;
            1: return 16'($urandom_range(0, 8000)) - 16'sd4000;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        logic signed [15:0] edge_vals[6];
        int mode;
        edge_vals = '{16'sh7FFF, -16'sh8000, 16'sd0, -16'sd1, 16'sd1, 16'sh5555};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, restarts while integrator zero
        write_reg(REG_ARM_LENGTH, 32'hFFFF);
        write_reg(REG_PHASE_GAIN, 32'h0100_0000);
        foreach (edge_vals[i]) send_gyro(edge_vals[i]);
        send_gyro(16'sh2AAA);
        for (int i = 0; i < 16; i++) send_gyro(16'(i * 7 - 50));
        settle();

        // random phases across several register settings
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin
                    write_reg(REG_REST_THRESHOLD, 32'd0);
                    write_reg(REG_PHASE_GAIN, 32'h8000_0000);
                    write_reg(REG_ARM_LENGTH, 32'd0);
                end
                1: begin
                    write_reg(REG_REST_THRESHOLD, 32'h7FFF);
                    write_reg(REG_PHASE_GAIN, 32'h7FFF_FFFF);
                    write_reg(REG_ARM_LENGTH, 32'hFFFF);
                end
                default: begin
                    write_reg(REG_REST_THRESHOLD, $urandom_range(0, 32767));
                    write_reg(REG_PHASE_GAIN, $urandom);
                    write_reg(REG_ARM_LENGTH, $urandom_range(0, 65535));
                end
            endcase
            if (ph == 3) begin
                // long receiver hold-off while the sender keeps offering
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (2000) @(posedge i_clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            for (int k = 0; k < 230; k++) begin
                mode = $urandom_range(0, 9);
                send_burst(rand_gyro(mode < 6 ? 0 : (mode < 9 ? 1 : 2)), ph != 1);
            end
            settle();
        end

        $display("sent %0d gyro beats, %0d bump results checked, 8 register settings",
                 sent, bump_count);
        if (fail_count == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end
endmodule
